### src/stff_pkg.sv
// ----------------------------------------------------------------------------
// stff_pkg
// Shared types and constants for the slot table with first-free hint.
// ----------------------------------------------------------------------------
package stff_pkg;

  localparam int SLOTS_DEF = 64;
  localparam int HW        = 16;   // handle width
  localparam int MW        = 2;    // mode width

  localparam logic [MW-1:0] MODE_ENQ  = 2'd0;
  localparam logic [MW-1:0] MODE_REM  = 2'd1;
  localparam logic [MW-1:0] MODE_NEXT = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic exec;   // item transfer this cycle: update state, latch result
    logic resp;   // result cycle
  } stff_cmd_t;

endpackage

### src/slot_table_first_free_unit.sv
// ----------------------------------------------------------------------------
// slot_table_first_free_unit
// Slot table of object handles with first-free hint, high-water mark and
// iteration cursor. Commands: enqueue, remove, get-next.
// ----------------------------------------------------------------------------
//  channel  | signals                                | transfer
//  ---------+----------------------------------------+---------------------
//  command  | start, busy, mode, handle, slot        | start && !busy
//  result   | done, ok, slot_out, handle_out,        | done (one cycle)
//           | slot_empty                             |
//
// On each command the transfer cycle updates the occupancy
// bits and hint/mark/cursor through a combinational lowest-set-bit scan and
// reads the handle memory; the next cycle presents the result with done.
// busy is high during that result cycle. Reset is synchronous and clears the
// occupancy bits and all pointers at once; handles are undefined until
// written. The receiver cannot stall.
// ----------------------------------------------------------------------------
module slot_table_first_free_unit #(
  parameter int SLOTS = stff_pkg::SLOTS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [stff_pkg::MW-1:0]   mode,
  input  logic [stff_pkg::HW-1:0]   handle,
  input  logic [$clog2(SLOTS)-1:0]  slot,
  output logic                      done,
  output logic                      ok,
  output logic [$clog2(SLOTS)-1:0]  slot_out,
  output logic [stff_pkg::HW-1:0]   handle_out,
  output logic                      slot_empty
);

  stff_pkg::stff_cmd_t cmd;

  stff_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  stff_dpath #(
    .SLOTS (SLOTS)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .mode       (mode),
    .handle     (handle),
    .slot       (slot),
    .ok         (ok),
    .slot_out   (slot_out),
    .handle_out (handle_out),
    .slot_empty (slot_empty)
  );

endmodule

### src/stff_ctrl.sv
// ----------------------------------------------------------------------------
// stff_ctrl
// Two-state sequencer: takes a command, then presents its result one cycle.
// ----------------------------------------------------------------------------
module stff_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  output logic              done,
  output stff_pkg::stff_cmd_t cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RESP = 1'b1;

  logic state;
  logic state_next;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) state_next = ST_RESP;
      end
      ST_RESP: begin
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy     = (state == ST_RESP);
  assign done     = (state == ST_RESP);
  assign cmd.exec = start && (state == ST_IDLE);
  assign cmd.resp = (state == ST_RESP);

endmodule

### src/stff_dpath.sv
// ----------------------------------------------------------------------------
// stff_dpath
// Occupancy bits, hint/mark/cursor registers, handle memory and the
// lowest-set-bit scan shared by enqueue and get-next.
// ----------------------------------------------------------------------------
module stff_dpath #(
  parameter int SLOTS = stff_pkg::SLOTS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  stff_pkg::stff_cmd_t       cmd,
  input  logic [stff_pkg::MW-1:0]   mode,
  input  logic [stff_pkg::HW-1:0]   handle,
  input  logic [$clog2(SLOTS)-1:0]  slot,
  output logic                      ok,
  output logic [$clog2(SLOTS)-1:0]  slot_out,
  output logic [stff_pkg::HW-1:0]   handle_out,
  output logic                      slot_empty
);

  localparam int SW = $clog2(SLOTS);
  localparam int PW = SW + 1;

  // state
  logic [SLOTS-1:0]        occ;
  logic [PW-1:0]           free_hint;
  logic [PW-1:0]           high_mark;
  logic [PW-1:0]           cursor;
  logic [stff_pkg::HW-1:0] mem [SLOTS];
  logic [stff_pkg::HW-1:0] handle_rd;

  // registered result
  logic          res_ok;
  logic [SW-1:0] res_slot;
  logic          res_empty;
  logic          res_hvalid;

  logic [SLOTS-1:0] occ_next;
  logic [PW-1:0]    free_hint_next;
  logic [PW-1:0]    high_mark_next;
  logic [PW-1:0]    cursor_next;
  logic             res_ok_next;
  logic [SW-1:0]    res_slot_next;
  logic             res_empty_next;
  logic             res_hvalid_next;

  logic [SLOTS-1:0] scan_m;
  logic [SLOTS-1:0] low_m;
  logic [SW-1:0]    scan_idx;
  logic             scan_hit;
  logic             we;
  logic             re;
  logic [SW-1:0]    rd_addr;
  logic [PW-1:0]    ext_slot;
  logic [PW-1:0]    scan_ext;

  // Scan mask: empty slots above the hint (enqueue) or occupied slots from
  // the cursor (get-next), both below the mark. Lowest set bit via x & -x.
  always_comb begin
    scan_m = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (mode == stff_pkg::MODE_ENQ) begin
        scan_m[i] = !occ[i] && (PW'(i) > free_hint) && (PW'(i) < high_mark);
      end else begin
        scan_m[i] = occ[i] && (PW'(i) >= cursor) && (PW'(i) < high_mark);
      end
    end
    low_m    = scan_m & (~scan_m + SLOTS'(1));
    scan_hit = |scan_m;
    scan_idx = '0;
    for (int i = 0; i < SLOTS; i++) begin
      scan_idx = scan_idx | ({SW{low_m[i]}} & SW'(i));
    end
  end

  always_comb begin
    occ_next        = occ;
    free_hint_next  = free_hint;
    high_mark_next  = high_mark;
    cursor_next     = cursor;
    res_ok_next     = 1'b0;
    res_slot_next   = '0;
    res_empty_next  = 1'b0;
    res_hvalid_next = 1'b0;
    we              = 1'b0;
    re              = 1'b0;
    rd_addr         = scan_idx;
    ext_slot        = {1'b0, slot};
    scan_ext        = {1'b0, scan_idx};
    if (cmd.exec) begin
      case (mode)
        stff_pkg::MODE_ENQ: begin
          if (free_hint < PW'(SLOTS - 1)) begin
            we                          = 1'b1;
            occ_next[free_hint[SW-1:0]] = 1'b1;
            res_ok_next                 = 1'b1;
            res_slot_next               = free_hint[SW-1:0];
            if (free_hint == high_mark) begin
              high_mark_next = high_mark + PW'(1);
              free_hint_next = high_mark + PW'(1);
            end else if (scan_hit) begin
              free_hint_next = scan_ext;
            end else begin
              free_hint_next = high_mark;
            end
          end
        end
        stff_pkg::MODE_REM: begin
          res_ok_next = 1'b1;
          if (ext_slot < PW'(SLOTS)) begin
            occ_next[slot] = 1'b0;
            if (ext_slot < free_hint) free_hint_next = ext_slot;
          end
        end
        stff_pkg::MODE_NEXT: begin
          if (cursor >= high_mark) begin
            cursor_next = '0;
          end else if (scan_hit) begin
            re              = 1'b1;
            res_ok_next     = 1'b1;
            res_slot_next   = scan_idx;
            res_hvalid_next = 1'b1;
            cursor_next     = scan_ext + PW'(1);
          end else begin
            // walked to the mark without a hit: report the last slot empty
            res_ok_next    = 1'b1;
            res_slot_next  = SW'(high_mark - PW'(1));
            res_empty_next = 1'b1;
            cursor_next    = high_mark;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ       <= '0;
      free_hint <= '0;
      high_mark <= '0;
      cursor    <= '0;
    end else begin
      occ       <= occ_next;
      free_hint <= free_hint_next;
      high_mark <= high_mark_next;
      cursor    <= cursor_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_ok     <= res_ok_next;
      res_slot   <= res_slot_next;
      res_empty  <= res_empty_next;
      res_hvalid <= res_hvalid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[free_hint[SW-1:0]] <= handle;
    if (re) handle_rd <= mem[rd_addr];
  end

  assign ok         = cmd.resp && res_ok;
  assign slot_out   = cmd.resp ? res_slot : '0;
  assign handle_out = (cmd.resp && res_hvalid) ? handle_rd : '0;
  assign slot_empty = cmd.resp && res_empty;

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for slot_table_first_free_unit: enqueue, remove and
// get-next commands from a short directed list, then random fill, remove,
// walk and mixed phases. It predicts every result and checks each done strobe.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int SLOTS = stff_pkg::SLOTS_DEF;
  localparam int SW    = $clog2(SLOTS);
  localparam int HW    = stff_pkg::HW;
  localparam int MW    = stff_pkg::MW;
  localparam int ITEMS = 1550;
  localparam logic [MW-1:0] MODE_UNUSED = 2'd3;

  typedef struct {
    logic          ok;
    logic [SW-1:0] slot_out;
    logic [HW-1:0] handle_out;
    logic          slot_empty;
  } slot_answer_t;

  // Predicts the table's answers and checks them in order.
  class slot_table_model_t;
    bit            occ[SLOTS];
    logic [HW-1:0] hstore[SLOTS];
    int            free_hint;
    int            high_mark;
    int            cursor_pos;
    slot_answer_t  answers_due[$];
    int            mismatches;
    int            checked;
    int            full_seen;
    int            ends_seen;
    int            empties_seen;

    function new();
      foreach (occ[i]) occ[i] = 1'b0;
      free_hint  = 0;
      high_mark  = 0;
      cursor_pos = 0;
      mismatches = 0;
      checked    = 0;
    endfunction

    function void note_command(logic [MW-1:0] m, logic [HW-1:0] h,
                               logic [SW-1:0] s);
      slot_answer_t a;
      int at;
      int idx;
      a = '{1'b0, '0, '0, 1'b0};
      case (m)
        stff_pkg::MODE_ENQ: begin
          at = free_hint;
          if (at >= SLOTS - 1) begin
            full_seen++;
          end else begin
            occ[at]    = 1'b1;
            hstore[at] = h;
            if (at == high_mark) begin
              high_mark++;
              free_hint = high_mark;
            end else begin
              free_hint = high_mark;
              for (int i = at; i < high_mark; i++) begin
                if (!occ[i]) begin
                  free_hint = i;
                  break;
                end
              end
            end
            a.ok       = 1'b1;
            a.slot_out = SW'(at);
          end
        end
        stff_pkg::MODE_REM: begin
          occ[s] = 1'b0;
          if (int'(s) < free_hint) free_hint = int'(s);
          a.ok = 1'b1;
        end
        stff_pkg::MODE_NEXT: begin
          if (cursor_pos >= high_mark) begin
            cursor_pos = 0;
            ends_seen++;
          end else begin
            idx = cursor_pos++;
            while (!occ[idx] && cursor_pos < high_mark) idx = cursor_pos++;
            a.ok       = 1'b1;
            a.slot_out = SW'(idx);
            if (occ[idx]) begin
              a.handle_out = hstore[idx];
            end else begin
              a.slot_empty = 1'b1;
              empties_seen++;
            end
          end
        end
        default: ;
      endcase
      answers_due.push_back(a);
    endfunction

    function void check_answer(logic o, logic [SW-1:0] so, logic [HW-1:0] ho, logic se);
      slot_answer_t a;
      if (answers_due.size() == 0) begin
        $error("result with nothing expected: ok=%0b slot_out=%0d handle_out=%h",
               o, so, ho);
        mismatches++;
        return;
      end
      a = answers_due.pop_front();
      checked++;
      if (o !== a.ok) begin
        $error("ok: expected %0b, got %0b", a.ok, o);
        mismatches++;
      end
      if (so !== a.slot_out) begin
        $error("slot_out: expected %0d, got %0d", a.slot_out, so);
        mismatches++;
      end
      if (ho !== a.handle_out) begin
        $error("handle_out: expected %h, got %h", a.handle_out, ho);
        mismatches++;
      end
      if (se !== a.slot_empty) begin
        $error("slot_empty: expected %0b, got %0b", a.slot_empty, se);
        mismatches++;
      end
    endfunction

    function int pick_occupied();
      int used[$];
      for (int i = 0; i < high_mark; i++) if (occ[i]) used.push_back(i);
      if (used.size() == 0) return -1;
      return used[$urandom_range(0, used.size() - 1)];
    endfunction
  endclass

  logic          clk;
  logic          rst;
  logic          start;
  logic          busy;
  logic [MW-1:0] mode;
  logic [HW-1:0] handle;
  logic [SW-1:0] slot;
  logic          done;
  logic          ok;
  logic [SW-1:0] slot_out;
  logic [HW-1:0] handle_out;
  logic          slot_empty;

  slot_table_model_t model = new();
  int  sent;
  bit  idle_en;
  bit  first_phase;

  slot_table_first_free_unit #(.SLOTS(SLOTS)) u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .mode(mode), .handle(handle), .slot(slot),
    .done(done), .ok(ok), .slot_out(slot_out),
    .handle_out(handle_out), .slot_empty(slot_empty)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && done) model.check_answer(ok, slot_out, handle_out, slot_empty);
  end

  initial begin
    #3_000_000;
    $display("Some tests failed");
    $finish;
  end

  function logic [HW-1:0] rand_handle();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return HW'($urandom);
    endcase
  endfunction

  // One command transfer; a random idle burst may come first.
  task automatic issue(logic [MW-1:0] m, logic [HW-1:0] h, logic [SW-1:0] s);
    int gap;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 19);
      @(negedge clk);
      start  = 1'b0;
      mode   = MW'($urandom);
      handle = HW'($urandom);
      slot   = SW'($urandom);
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start  = 1'b1;
    mode   = m;
    handle = h;
    slot   = s;
    do @(posedge clk); while (busy);
    model.note_command(m, h, s);
    sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    start = 1'b0;
    while (model.answers_due.size() != 0) @(posedge clk);
  endtask

  task automatic remove_one();
    int s;
    s = model.pick_occupied();
    if (s < 0 || $urandom_range(0, 4) == 0) s = $urandom_range(0, SLOTS - 1);
    issue(stff_pkg::MODE_REM, HW'($urandom), SW'(s));
  endtask

  initial begin
    int n;
    int r;
    rst     = 1'b1;
    start   = 1'b0;
    mode    = '0;
    handle  = '0;
    slot    = '0;
    sent    = 0;
    idle_en = 1'b1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: end of walk on an empty table, handle extremes, removes of
    // occupied, empty and top slots, skip over a hole, empty slot at the mark
    issue(stff_pkg::MODE_NEXT, '0, '0);
    issue(stff_pkg::MODE_ENQ, '0, '1);
    issue(stff_pkg::MODE_ENQ, '1, '0);
    issue(stff_pkg::MODE_ENQ, 16'h1234, '0);
    issue(stff_pkg::MODE_NEXT, '0, '0);
    issue(stff_pkg::MODE_REM, '0, SW'(1));
    issue(stff_pkg::MODE_REM, '1, SW'(1));
    issue(stff_pkg::MODE_REM, '0, '1);
    issue(stff_pkg::MODE_NEXT, '1, '1);
    issue(stff_pkg::MODE_NEXT, '0, '0);
    issue(stff_pkg::MODE_NEXT, '0, '0);
    issue(stff_pkg::MODE_ENQ, 16'hA5A5, '0);
    issue(stff_pkg::MODE_REM, '0, SW'(2));
    issue(stff_pkg::MODE_NEXT, '0, '0);
    issue(stff_pkg::MODE_NEXT, '0, '0);
    issue(stff_pkg::MODE_NEXT, '0, '0);
    issue(stff_pkg::MODE_NEXT, '0, '0);
    issue(MODE_UNUSED, '1, '1);
    issue(MODE_UNUSED, '0, '0);
    issue(stff_pkg::MODE_REM, '0, '0);
    issue(stff_pkg::MODE_ENQ, 16'h8001, '1);
    wait_drained();

    first_phase = 1'b1;
    while (sent < ITEMS) begin
      if (sent > ITEMS * 85 / 100) idle_en = 1'b0;
      r = first_phase ? 0 : $urandom_range(0, 3);
      case (r)
        0: begin
          // fill runs long enough to hit the full table now and then
          n = first_phase ? 70 : $urandom_range(5, 70);
          repeat (n) issue(stff_pkg::MODE_ENQ, rand_handle(), SW'($urandom));
        end
        1: begin
          n = $urandom_range(3, 30);
          repeat (n) remove_one();
        end
        2: begin
          n = model.high_mark - model.cursor_pos + 2;
          repeat (n) issue(stff_pkg::MODE_NEXT, HW'($urandom), SW'($urandom));
        end
        default: begin
          n = $urandom_range(10, 40);
          repeat (n) begin
            r = $urandom_range(0, 15);
            if (r == 0) issue(MODE_UNUSED, HW'($urandom), SW'($urandom));
            else if (r < 7) issue(stff_pkg::MODE_ENQ, rand_handle(), SW'($urandom));
            else if (r < 11) remove_one();
            else issue(stff_pkg::MODE_NEXT, HW'($urandom), SW'($urandom));
          end
        end
      endcase
      first_phase = 1'b0;
      if ($urandom_range(0, 3) == 0) wait_drained();
    end

    wait_drained();
    repeat (4) @(posedge clk);
    $display("Run covered %0d command transfers, %0d results checked, %0d mismatches.",
             sent, model.checked, model.mismatches);
    $display("Table-full enqueues %0d, walk ends %0d, empty slots at the mark %0d.",
             model.full_seen, model.ends_seen, model.empties_seen);
    if (model.mismatches == 0 && model.answers_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
